// File: rtl/core/csht_pkg.sv
// ----------------------------------------------------------------------------
// csht_pkg
// Shared types and constants for the circle / thick segment hit test pipeline.
// ----------------------------------------------------------------------------
package csht_pkg;

    localparam int COORD_W = 16;               // Q12.4 coordinates, Q8.8 scale
    localparam int DIFF_W  = COORD_W + 1;      // coordinate differences
    localparam int PROD_W  = 2 * DIFF_W;       // signed product of two differences
    localparam int SUM_W   = PROD_W + 1;       // signed sum of two products
    localparam int LEN_W   = PROD_W;           // unsigned squared length
    localparam int T_W     = 2 * COORD_W + 1;  // threshold weight*256 + radius*scale
    localparam int TC_W    = 26;               // threshold bits kept below the big limit
    localparam int T2_W    = 2 * TC_W;         // squared threshold
    localparam int HALF_W  = LEN_W / 2;        // split point of 34-bit multiplicands

    typedef enum logic [1:0] {
        REG_ZERO   = 2'd0,   // zero-length segment
        REG_BEFORE = 2'd1,   // projection before the first endpoint
        REG_PAST   = 2'd2,   // projection past the second endpoint
        REG_INSIDE = 2'd3    // projection on the segment
    } t_region;

    typedef struct packed {
        logic signed [COORD_W-1:0] circle_x;
        logic signed [COORD_W-1:0] circle_y;
        logic        [COORD_W-1:0] radius;
        logic        [COORD_W-1:0] scale;
        logic signed [COORD_W-1:0] seg_ax;
        logic signed [COORD_W-1:0] seg_ay;
        logic signed [COORD_W-1:0] seg_bx;
        logic signed [COORD_W-1:0] seg_by;
        logic        [COORD_W-1:0] weight;
    } t_hit_in;

    typedef struct packed {
        logic       hit;
        logic [1:0] region;
    } t_hit_out;

    // Products leaving the front end
    typedef struct packed {
        logic                     vld;
        logic                     big;
        logic        [T2_W-1:0]   t2;
        logic signed [PROD_W-1:0] sq_dx;
        logic signed [PROD_W-1:0] sq_dy;
        logic signed [PROD_W-1:0] dot_x;
        logic signed [PROD_W-1:0] dot_y;
        logic signed [PROD_W-1:0] cr_a;
        logic signed [PROD_W-1:0] cr_b;
        logic signed [PROD_W-1:0] sq_wx;
        logic signed [PROD_W-1:0] sq_wy;
        logic signed [PROD_W-1:0] sq_ex;
        logic signed [PROD_W-1:0] sq_ey;
    } t_prod;

    // Classified geometry leaving the middle section
    typedef struct packed {
        logic             vld;
        logic             big;
        t_region          region;
        logic [T2_W-1:0]  t2;
        logic [LEN_W-1:0] len2;
        logic [LEN_W-1:0] ac;
        logic [LEN_W-1:0] d2;
    } t_geom;

endpackage

// File: rtl/core/csht_prep.sv
// ----------------------------------------------------------------------------
// csht_prep
// Front end: differences and threshold, then all 17x17 products and T^2.
// ----------------------------------------------------------------------------
module csht_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  csht_pkg::t_hit_in i_data,
    output csht_pkg::t_prod   o_prod
);
    import csht_pkg::*;

    logic signed [DIFF_W-1:0] n_dx, n_dy, n_wx, n_wy, n_ex, n_ey;
    logic        [2*COORD_W-1:0] n_rs;
    logic        [T_W-1:0]    n_t;

    logic                     r_s1_vld;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_wx, r_wy, r_ex, r_ey;
    logic        [T_W-1:0]    r_t;

    t_prod n_prod;
    t_prod r_prod;

    // Stage 1: differences and threshold
    assign n_dx = i_data.seg_bx   - i_data.seg_ax;
    assign n_dy = i_data.seg_by   - i_data.seg_ay;
    assign n_wx = i_data.circle_x - i_data.seg_ax;
    assign n_wy = i_data.circle_y - i_data.seg_ay;
    assign n_ex = i_data.circle_x - i_data.seg_bx;
    assign n_ey = i_data.circle_y - i_data.seg_by;
    assign n_rs = i_data.radius * i_data.scale;
    assign n_t  = {1'b0, n_rs} + {{(T_W-COORD_W-8){1'b0}}, i_data.weight, 8'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_wx <= n_wx;
        r_wy <= n_wy;
        r_ex <= n_ex;
        r_ey <= n_ey;
        r_t  <= n_t;
    end

    // Stage 2: products
    always_comb begin
        n_prod       = r_prod;
        n_prod.vld   = r_s1_vld;
        n_prod.big   = |r_t[T_W-1:TC_W];
        n_prod.t2    = r_t[TC_W-1:0] * r_t[TC_W-1:0];
        n_prod.sq_dx = r_dx * r_dx;
        n_prod.sq_dy = r_dy * r_dy;
        n_prod.dot_x = r_wx * r_dx;
        n_prod.dot_y = r_wy * r_dy;
        n_prod.cr_a  = r_wy * r_dx;
        n_prod.cr_b  = r_wx * r_dy;
        n_prod.sq_wx = r_wx * r_wx;
        n_prod.sq_wy = r_wy * r_wy;
        n_prod.sq_ex = r_ex * r_ex;
        n_prod.sq_ey = r_ey * r_ey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.vld <= 1'b0;
        end else begin
            r_prod.vld <= n_prod.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod.big   <= n_prod.big;
        r_prod.t2    <= n_prod.t2;
        r_prod.sq_dx <= n_prod.sq_dx;
        r_prod.sq_dy <= n_prod.sq_dy;
        r_prod.dot_x <= n_prod.dot_x;
        r_prod.dot_y <= n_prod.dot_y;
        r_prod.cr_a  <= n_prod.cr_a;
        r_prod.cr_b  <= n_prod.cr_b;
        r_prod.sq_wx <= n_prod.sq_wx;
        r_prod.sq_wy <= n_prod.sq_wy;
        r_prod.sq_ex <= n_prod.sq_ex;
        r_prod.sq_ey <= n_prod.sq_ey;
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/csht_geom.sv
// ----------------------------------------------------------------------------
// csht_geom
// Middle section: sums of products, then region classification, |cross| and
// the endpoint distance for the region.
// ----------------------------------------------------------------------------
module csht_geom (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csht_pkg::t_prod i_prod,
    output csht_pkg::t_geom o_geom
);
    import csht_pkg::*;

    logic        [LEN_W-1:0] n_len2, n_d2a, n_d2b;
    logic signed [SUM_W-1:0] n_dot, n_cr;

    logic                    r_s3_vld;
    logic                    r_big;
    logic        [T2_W-1:0]  r_t2;
    logic        [LEN_W-1:0] r_len2, r_d2a, r_d2b;
    logic signed [SUM_W-1:0] r_dot, r_cr;

    t_region          n_region;
    logic [SUM_W-1:0] n_neg_cr;
    t_geom            n_geom;
    t_geom            r_geom;

    // Stage 3: sums; squared sums are never negative and fit unsigned
    assign n_len2 = i_prod.sq_dx + i_prod.sq_dy;
    assign n_d2a  = i_prod.sq_wx + i_prod.sq_wy;
    assign n_d2b  = i_prod.sq_ex + i_prod.sq_ey;
    assign n_dot  = i_prod.dot_x + i_prod.dot_y;
    assign n_cr   = i_prod.cr_a  - i_prod.cr_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= i_prod.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_big  <= i_prod.big;
        r_t2   <= i_prod.t2;
        r_len2 <= n_len2;
        r_d2a  <= n_d2a;
        r_d2b  <= n_d2b;
        r_dot  <= n_dot;
        r_cr   <= n_cr;
    end

    // Stage 4: classify; a projection landing exactly on an endpoint is interior
    always_comb begin
        priority if (r_len2 == '0) begin
            n_region = REG_ZERO;
        end else if (r_dot < 0) begin
            n_region = REG_BEFORE;
        end else if (r_dot > $signed({1'b0, r_len2})) begin
            n_region = REG_PAST;
        end else begin
            n_region = REG_INSIDE;
        end
    end

    assign n_neg_cr = -r_cr;

    always_comb begin
        n_geom        = r_geom;
        n_geom.vld    = r_s3_vld;
        n_geom.big    = r_big;
        n_geom.region = n_region;
        n_geom.t2     = r_t2;
        n_geom.len2   = r_len2;
        n_geom.ac     = r_cr[SUM_W-1] ? n_neg_cr[LEN_W-1:0] : r_cr[LEN_W-1:0];
        n_geom.d2     = (n_region == REG_PAST) ? r_d2b : r_d2a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.vld <= 1'b0;
        end else begin
            r_geom.vld <= n_geom.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_geom.big    <= n_geom.big;
        r_geom.region <= n_geom.region;
        r_geom.t2     <= n_geom.t2;
        r_geom.len2   <= n_geom.len2;
        r_geom.ac     <= n_geom.ac;
        r_geom.d2     <= n_geom.d2;
    end

    assign o_geom = r_geom;

endmodule

// File: rtl/core/csht_cmp.sv
// ----------------------------------------------------------------------------
// csht_cmp
// Back end: split wide squares into partial products, sum them, and do the
// final exact compares that decide the hit.
// ----------------------------------------------------------------------------
module csht_cmp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csht_pkg::t_geom    i_geom,
    output logic               o_valid,
    output csht_pkg::t_hit_out o_result
);
    import csht_pkg::*;

    localparam int TH_W  = T2_W - TC_W;          // upper half of T^2
    localparam int LH_W  = LEN_W - HALF_W;       // upper half of 34-bit values
    localparam int PA_W  = 2 * LH_W;             // 17x17 partial product
    localparam int PR_W  = TH_W + LH_W;          // 26x17 partial product
    localparam int LHS_W = 2 * LEN_W;            // |cross|^2
    localparam int RH_W  = PR_W + HALF_W + 1;    // half sums of T^2 * len2
    localparam int RHS_W = RH_W + TC_W + 1;      // T^2 * len2
    localparam int NEAR_W = LEN_W + 16;          // d2 scaled by 2^16

    // Stage 5
    logic            r_s5_vld;
    logic            r_s5_big, r_near;
    t_region         r_s5_region;
    logic [PA_W-1:0] r_pa_hh, r_pa_hl, r_pa_ll;
    logic [PR_W-1:0] r_pr_hh, r_pr_hl, r_pr_lh, r_pr_ll;
    logic            n_near;

    // Stage 6
    logic             r_s6_vld;
    logic             r_s6_big, r_s6_near;
    t_region          r_s6_region;
    logic [LHS_W-1:0] r_lhs, n_lhs;
    logic [RH_W-1:0]  r_rhs_hi, r_rhs_lo, n_rhs_hi, n_rhs_lo;

    // Stage 7
    logic [RHS_W-1:0] n_rhs, n_lhs_sc;
    logic             n_hit;
    logic             r_valid;
    t_hit_out         r_result;

    // Stage 5: partial products; compare endpoint distance against T^2 here
    assign n_near = {{(T2_W-NEAR_W){1'b0}}, i_geom.d2, 16'b0} < i_geom.t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= i_geom.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_big    <= i_geom.big;
        r_s5_region <= i_geom.region;
        r_near      <= n_near;
        r_pa_hh     <= i_geom.ac[LEN_W-1:HALF_W] * i_geom.ac[LEN_W-1:HALF_W];
        r_pa_hl     <= i_geom.ac[LEN_W-1:HALF_W] * i_geom.ac[HALF_W-1:0];
        r_pa_ll     <= i_geom.ac[HALF_W-1:0]     * i_geom.ac[HALF_W-1:0];
        r_pr_hh     <= i_geom.t2[T2_W-1:TC_W]    * i_geom.len2[LEN_W-1:HALF_W];
        r_pr_hl     <= i_geom.t2[T2_W-1:TC_W]    * i_geom.len2[HALF_W-1:0];
        r_pr_lh     <= i_geom.t2[TC_W-1:0]       * i_geom.len2[LEN_W-1:HALF_W];
        r_pr_ll     <= i_geom.t2[TC_W-1:0]       * i_geom.len2[HALF_W-1:0];
    end

    // Stage 6: |cross|^2 in full, T^2 * len2 as two half sums
    assign n_lhs = ({{(LHS_W-PA_W){1'b0}}, r_pa_hh} << (2 * HALF_W))
                 + ({{(LHS_W-PA_W){1'b0}}, r_pa_hl} << (HALF_W + 1))
                 +  {{(LHS_W-PA_W){1'b0}}, r_pa_ll};
    assign n_rhs_hi = ({{(RH_W-PR_W){1'b0}}, r_pr_hh} << HALF_W)
                    +  {{(RH_W-PR_W){1'b0}}, r_pr_hl};
    assign n_rhs_lo = ({{(RH_W-PR_W){1'b0}}, r_pr_lh} << HALF_W)
                    +  {{(RH_W-PR_W){1'b0}}, r_pr_ll};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_big    <= r_s5_big;
        r_s6_near   <= r_near;
        r_s6_region <= r_s5_region;
        r_lhs       <= n_lhs;
        r_rhs_hi    <= n_rhs_hi;
        r_rhs_lo    <= n_rhs_lo;
    end

    // Stage 7: final add and compare, then pick the test for the region
    assign n_rhs    = ({{(RHS_W-RH_W){1'b0}}, r_rhs_hi} << TC_W)
                    +  {{(RHS_W-RH_W){1'b0}}, r_rhs_lo};
    assign n_lhs_sc = {{(RHS_W-LHS_W-16){1'b0}}, r_lhs, 16'b0};

    always_comb begin
        priority if (r_s6_big) begin
            n_hit = 1'b1;
        end else if (r_s6_region == REG_INSIDE) begin
            n_hit = n_lhs_sc < n_rhs;
        end else begin
            n_hit = r_s6_near;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.hit    <= n_hit;
        r_result.region <= r_s6_region;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/core/circle_segment_hit_test.sv
// ----------------------------------------------------------------------------
// circle_segment_hit_test
// Exact hit test between a scaled circle and a thick line segment.
// ----------------------------------------------------------------------------
// A new beat is taken on every clock where start is high; busy never rises,
// since the block is a fully pipelined multiplier datapath with no shared
// unit. Each beat produces exactly one result, shown for a single cycle with
// o_valid high; results come out in input order, one per cycle at most, and
// the receiver cannot hold them off, so capture o_result whenever o_valid is
// high. The result passes through a chain of product stages: differences,
// 17x17 products, sums and region classification, then the split 34x34 and
// 52x34 squared products for the exact compare.
// Region reports zero-length segment, before the first endpoint, past the
// second endpoint, or interior; a projection landing exactly on an endpoint
// counts as interior. Hit uses a strict less-than on squared distances, with
// threshold weight + radius * scale; a threshold at or above 2^26 (Q.12) hits.
// ----------------------------------------------------------------------------
module circle_segment_hit_test (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  csht_pkg::t_hit_in  i_data,
    output logic               o_valid,
    output csht_pkg::t_hit_out o_result
);
    import csht_pkg::*;

    logic  w_accept;
    t_prod w_prod;
    t_geom w_geom;

    // Never stall: every cycle has room for a new beat
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Differences, threshold, and all first-level products
    csht_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_data  (i_data),
        .o_prod  (w_prod)
    );

    // Sums, region classification, |cross| and endpoint distance
    csht_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (w_prod),
        .o_geom  (w_geom)
    );

    // Wide squared products and the final compare
    csht_cmp u_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_geom   (w_geom),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the circle / thick segment hit test pipeline.
// ----------------------------------------------------------------------------
// A queue of pending beats is filled up front. It holds a directed block first:
// degenerate segments, endpoint tangency, projections landing exactly on an
// endpoint, the threshold limit and all-zero / all-one fields. A random block
// follows, mostly geometry built near the decision boundary, the rest noise.
// The driver issues beats with random gaps. The monitor predicts every taken
// beat with an exact wide-integer model and checks each strobed result, field
// by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    import csht_pkg::*;

    localparam int RANDOM_BEATS = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_hit_in  i_data  = '0;
    logic     o_valid;
    t_hit_out o_result;

    t_hit_in  pending_beats[$];
    t_hit_out expected_results[$];

    int beats_total    = 0;
    int beats_accepted = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int idle_left      = 0;
    bit burst_mode     = 1'b0;

    circle_segment_hit_test u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Exact hit prediction. Distances are squared and compared in Q.12 units:
    // a squared Q.4 distance is shifted up by 16 and set against the squared
    // threshold. The interior case multiplies the squared threshold by the
    // squared segment length rather than dividing, so it needs 128 bits.
    // ------------------------------------------------------------------------
    function automatic t_hit_out predict_hit_test(t_hit_in h);
        longint       px, py, ax, ay, bx, by;
        longint       dx, dy, wx, wy, ex, ey;
        longint       thr, len2, dot, crs, d2;
        logic [127:0] crs_w, lhs, rhs;
        t_region      zone;
        t_hit_out     r;
        px  = $signed(h.circle_x);
        py  = $signed(h.circle_y);
        ax  = $signed(h.seg_ax);
        ay  = $signed(h.seg_ay);
        bx  = $signed(h.seg_bx);
        by  = $signed(h.seg_by);
        thr = longint'(h.weight) * 256 + longint'(h.radius) * longint'(h.scale);
        dx  = bx - ax;
        dy  = by - ay;
        wx  = px - ax;
        wy  = py - ay;
        ex  = px - bx;
        ey  = py - by;
        len2 = dx * dx + dy * dy;
        // Classify where the center projects; an exact hit on an endpoint
        // still counts as interior.
        if (len2 == 0) begin
            zone = REG_ZERO;
        end else begin
            dot = wx * dx + wy * dy;
            if (dot < 0)
                zone = REG_BEFORE;
            else if (dot > len2)
                zone = REG_PAST;
            else
                zone = REG_INSIDE;
        end
        // A threshold at or above 2^26 outreaches any distance the
        // coordinates allow.
        if (thr >= (64'sd1 << 26)) begin
            r.hit = 1'b1;
        end else if (zone == REG_INSIDE) begin
            crs = wy * dx - wx * dy;
            if (crs < 0) crs = -crs;
            crs_w = 128'(crs);
            lhs   = (crs_w * crs_w) << 16;
            rhs   = 128'(thr * thr) * 128'(len2);
            r.hit = (lhs < rhs);
        end else begin
            d2    = (zone == REG_PAST) ? ex * ex + ey * ey : wx * wx + wy * wy;
            r.hit = ((d2 << 16) < thr * thr);
        end
        r.region = zone;
        return r;
    endfunction

    function automatic t_hit_in make_beat(int cx, int cy, int rad, int scl,
                                          int ax, int ay, int bx, int by, int wgt);
        t_hit_in h;
        h.circle_x = 16'(cx);
        h.circle_y = 16'(cy);
        h.radius   = 16'(rad);
        h.scale    = 16'(scl);
        h.seg_ax   = 16'(ax);
        h.seg_ay   = 16'(ay);
        h.seg_bx   = 16'(bx);
        h.seg_by   = 16'(by);
        h.weight   = 16'(wgt);
        return h;
    endfunction

    function automatic t_hit_in random_fields();
        return make_beat($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Signed offset in [-span, span], wrapped to the field width.
    function automatic logic [15:0] jitter(int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random pair: a fifth pure noise, the rest a short segment with the circle,
    // and mostly the threshold, on the same scale, so hits and misses mix.
    function automatic t_hit_in random_pair();
        t_hit_in h;
        int      kind, span, k, dx, dy;
        kind = $urandom_range(0, 9);
        h    = random_fields();
        if (kind <= 1) return h;
        span     = 1 << $urandom_range(2, 13);
        h.seg_bx = h.seg_ax + jitter(span);
        h.seg_by = h.seg_ay + jitter(span);
        if (kind == 2) begin
            h.seg_bx = h.seg_ax;
            h.seg_by = h.seg_ay;
        end
        dx = int'($signed(h.seg_bx)) - int'($signed(h.seg_ax));
        dy = int'($signed(h.seg_by)) - int'($signed(h.seg_ay));
        k  = int'($urandom_range(0, 4)) - 2;
        case (kind)
            3: begin
                // Center on the normal through the first endpoint: dot is zero.
                h.circle_x = 16'(int'($signed(h.seg_ax)) - k * dy);
                h.circle_y = 16'(int'($signed(h.seg_ay)) + k * dx);
            end
            4: begin
                // Center on the normal through the second endpoint: dot equals len2.
                h.circle_x = 16'(int'($signed(h.seg_bx)) - k * dy);
                h.circle_y = 16'(int'($signed(h.seg_by)) + k * dx);
            end
            default: begin
                h.circle_x = h.seg_ax + jitter(2 * span);
                h.circle_y = h.seg_ay + jitter(2 * span);
            end
        endcase
        if (kind != 9) begin
            h.weight = 16'($urandom_range(0, span));
            h.radius = 16'($urandom_range(0, span));
            h.scale  = 16'($urandom_range(0, 300));
        end
        return h;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0d] mismatch: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        // Zero-length segments: all zero (zero threshold), center on the
        // point, far apart.
        pending_beats.push_back(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(100, 100, 0, 0, 100, 100, 100, 100, 1));
        pending_beats.push_back(make_beat(-32768, -32768, 0, 0,
                                          32767, 32767, 32767, 32767, 100));
        // Before the first endpoint: exact tangency misses, one more LSB hits.
        pending_beats.push_back(make_beat(-32, 0, 0, 0, 0, 0, 160, 0, 32));
        pending_beats.push_back(make_beat(-32, 0, 0, 0, 0, 0, 160, 0, 33));
        // Past the second endpoint, radius times scale in the threshold.
        pending_beats.push_back(make_beat(192, 0, 16, 256, 0, 0, 160, 0, 16));
        pending_beats.push_back(make_beat(192, 0, 16, 256, 0, 0, 160, 0, 17));
        // Interior, perpendicular tangency and just inside.
        pending_beats.push_back(make_beat(80, 32, 0, 0, 0, 0, 160, 0, 32));
        pending_beats.push_back(make_beat(80, 32, 0, 0, 0, 0, 160, 0, 33));
        // Projection exactly on the first endpoint, then on the second.
        pending_beats.push_back(make_beat(0, 50, 0, 0, 0, 0, 100, 0, 60));
        pending_beats.push_back(make_beat(100, 50, 0, 0, 0, 0, 100, 0, 40));
        pending_beats.push_back(make_beat(130, 70, 0, 0, 0, 0, 100, 100, 30));
        // Huge threshold: maximum weight, radius and scale.
        pending_beats.push_back(make_beat(-32768, -32768, 65535, 65535,
                                          32767, 32767, 32767, 32767, 65535));
        // Threshold exactly at the big limit, and one below it.
        pending_beats.push_back(make_beat(-32768, -32768, 16384, 4096,
                                          32767, 32767, 32767, -32768, 0));
        pending_beats.push_back(make_beat(-32768, -32768, 8191, 8193,
                                          32767, 32767, 32767, -32768, 0));
        // Zero threshold with one factor of the product nonzero.
        pending_beats.push_back(make_beat(50, 0, 1000, 0, 0, 0, 100, 0, 0));
        pending_beats.push_back(make_beat(50, 0, 0, 1000, 0, 0, 100, 0, 0));
        // Extreme coordinates: full diagonal, all ones, most negative values.
        pending_beats.push_back(make_beat(32767, -32768, 100, 256,
                                          -32768, -32768, 32767, 32767, 0));
        pending_beats.push_back(make_beat(-1, -1, 65535, 65535, -1, -1, -1, -1, 65535));
        pending_beats.push_back(make_beat(-32768, -32768, 0, 0,
                                          -32768, -32768, 32767, -32768, 0));
        pending_beats.push_back(make_beat(32767, 32767, 1, 1, -32768, -32768, 0, 0, 1));
        pending_beats.push_back(make_beat(-32768, 0, 0, 0, 0, 0, 32767, 0, 65535));

        repeat (RANDOM_BEATS) pending_beats.push_back(random_pair());
        beats_total = pending_beats.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every beat to be taken, then let the pipeline drain.
        while (beats_accepted < beats_total) @(posedge i_clk);
        for (int n = 0; n < DRAIN_CYCLES && expected_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_results.size()));
        if (mismatch_count == 0)
            $display("circle_segment_hit_test regression: pass");
        else
            $display("circle_segment_hit_test regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: hold a beat while busy, otherwise advance to the next one after
    // a random gap. Now and then flip into a burst mode that drops the gaps
    // entirely, so back-to-back beats are covered too. Idle cycles carry random
    // data to prove that it is ignored.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                // Beat taken at this edge: draw the gap before the next one.
                if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
                idle_left = burst_mode ? 0 : $urandom_range(0, 10);
            end
            if (idle_left == 0 && pending_beats.size() != 0) begin
                start  <= 1'b1;
                i_data <= pending_beats.pop_front();
            end else begin
                start  <= 1'b0;
                i_data <= random_fields();
                if (idle_left != 0) idle_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: record the prediction for a beat taken at this edge first, so
    // even a result strobed at the same edge as its beat would find its match,
    // then check any strobed result against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_hit_out want;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(predict_hit_test(i_data));
                beats_accepted++;
            end
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result hit=%0b region=%0d",
                                              o_result.hit, o_result.region));
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.hit !== want.hit)
                        report_mismatch($sformatf("result %0d hit got %0b want %0b",
                                                  results_seen, o_result.hit, want.hit));
                    if (o_result.region !== want.region)
                        report_mismatch($sformatf("result %0d region got %0d want %0d",
                                                  results_seen, o_result.region,
                                                  want.region));
                end
                results_seen++;
            end
        end
    end

    // Drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("circle_segment_hit_test regression: fail");
            $finish;
        end
    end

endmodule

// File: circle_segment_hit_test.f
rtl/core/csht_pkg.sv
rtl/core/csht_prep.sv
rtl/core/csht_geom.sv
rtl/core/csht_cmp.sv
rtl/core/circle_segment_hit_test.sv
test/testbench.sv
